### rtl/csrd_pkg.sv
// ----------------------------------------------------------------------------
// csrd_pkg
// shared constants and types for the character screen rectangle drawer
// ----------------------------------------------------------------------------
package csrd_pkg;

   localparam int DEF_COLS = 64;
   localparam int DEF_ROWS = 32;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;
   localparam int SIZE_W  = 9;
   localparam int CRD_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] RST_CLEAR_CHAR  = 8'd32;
   localparam logic [CHAR_W-1:0] RST_HORIZ_CHAR  = 8'd45;
   localparam logic [CHAR_W-1:0] RST_VERT_CHAR   = 8'd124;
   localparam logic [CHAR_W-1:0] RST_CORNER_CHAR = 8'd43;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SET   = 2'd1,
      CMD_RECT  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CLEAR_CHAR  = 2'd0,
      REG_HORIZ_CHAR  = 2'd1,
      REG_VERT_CHAR   = 2'd2,
      REG_CORNER_CHAR = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [CHAR_W-1:0] clear_char;
      logic [CHAR_W-1:0] horiz_char;
      logic [CHAR_W-1:0] vert_char;
      logic [CHAR_W-1:0] corner_char;
   } char_set_type;

endpackage

### rtl/csrd_cell_mem.sv
// ----------------------------------------------------------------------------
// csrd_cell_mem
// screen cell memory, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module csrd_cell_mem #(
   parameter int DEPTH = csrd_pkg::DEF_COLS * csrd_pkg::DEF_ROWS,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [csrd_pkg::CHAR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [csrd_pkg::CHAR_W-1:0] rd_data
);

   logic [csrd_pkg::CHAR_W-1:0] cells [DEPTH];
   logic [csrd_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/csrd_draw_seq.sv
// ----------------------------------------------------------------------------
// csrd_draw_seq
// command sequencer: clear sweep, cell set, rectangle outline walk, cell read
// ----------------------------------------------------------------------------
module csrd_draw_seq #(
   parameter int COLS = csrd_pkg::DEF_COLS,
   parameter int ROWS = csrd_pkg::DEF_ROWS,
   parameter int AW   = (COLS * ROWS > 1) ? $clog2(COLS * ROWS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic signed [csrd_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [csrd_pkg::POS_W-1:0]   req_pos_y,
   input  logic [csrd_pkg::SIZE_W-1:0]         req_rect_width,
   input  logic [csrd_pkg::SIZE_W-1:0]         req_rect_height,
   input  logic [csrd_pkg::CHAR_W-1:0]         req_cell_char,
   input  csrd_pkg::char_set_type              chars,
   output logic                                mem_wr_en,
   output logic [AW-1:0]                       mem_wr_addr,
   output logic [csrd_pkg::CHAR_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [AW-1:0]                       mem_rd_addr,
   input  logic [csrd_pkg::CHAR_W-1:0]         mem_rd_data,
   output logic                                rsp_strobe,
   output logic [csrd_pkg::COUNT_W-1:0]        rsp_write_count,
   output logic [csrd_pkg::CHAR_W-1:0]         rsp_read_char
);

   localparam int CW = csrd_pkg::CRD_W;
   localparam logic [AW-1:0] LAST_CELL = AW'(COLS * ROWS - 1);
   localparam logic signed [CW-1:0] COLS_S = CW'(COLS);
   localparam logic signed [CW-1:0] ROWS_S = CW'(ROWS);

   typedef enum logic [2:0] {
      S_FILL,
      S_IDLE,
      S_HORIZ,
      S_VERT,
      S_CORNER,
      S_RD_WAIT,
      S_RD_TAKE
   } state_type;

   state_type                           state_ff;
   logic                                init_ff;
   logic [AW-1:0]                       fill_ff;
   logic signed [CW-1:0]                x0_ff, y0_ff, x1_ff, y1_ff, i_ff;
   logic                                side_ff;
   logic [1:0]                          k_ff;
   logic [csrd_pkg::COUNT_W-1:0]        count_ff;
   logic                                mem_wr_en_ff;
   logic [AW-1:0]                       mem_wr_addr_ff;
   logic [csrd_pkg::CHAR_W-1:0]         mem_wr_data_ff;
   logic                                mem_rd_en_ff;
   logic [AW-1:0]                       mem_rd_addr_ff;
   logic                                rsp_strobe_ff;
   logic [csrd_pkg::COUNT_W-1:0]        rsp_write_count_ff;
   logic [csrd_pkg::CHAR_W-1:0]         rsp_read_char_ff;

   logic signed [CW-1:0]                req_x, req_y;
   logic signed [CW-1:0]                pt_x, pt_y;
   logic                                pt_on;
   logic [AW-1:0]                       pt_addr;
   csrd_pkg::cmd_type                   cmd;

   assign cmd   = csrd_pkg::cmd_type'(req_command);
   assign req_x = {{(CW - csrd_pkg::POS_W){req_pos_x[csrd_pkg::POS_W-1]}}, req_pos_x};
   assign req_y = {{(CW - csrd_pkg::POS_W){req_pos_y[csrd_pkg::POS_W-1]}}, req_pos_y};

   // current point of the walk
   always_comb begin
      pt_x = req_x;
      pt_y = req_y;
      unique case (state_ff)
         S_HORIZ: begin
            pt_x = i_ff;
            pt_y = side_ff ? y1_ff : y0_ff;
         end
         S_VERT: begin
            pt_x = side_ff ? x1_ff : x0_ff;
            pt_y = i_ff;
         end
         S_CORNER: begin
            case (k_ff)
               2'd0: begin
                  pt_x = x0_ff;
                  pt_y = y0_ff;
               end
               2'd1: begin
                  pt_x = x1_ff;
                  pt_y = y0_ff;
               end
               2'd2: begin
                  pt_x = x1_ff;
                  pt_y = y1_ff;
               end
               default: begin
                  pt_x = x0_ff;
                  pt_y = y1_ff;
               end
            endcase
         end
         S_FILL, S_IDLE, S_RD_WAIT, S_RD_TAKE: begin
            pt_x = req_x;
            pt_y = req_y;
         end
         default: begin
            pt_x = req_x;
            pt_y = req_y;
         end
      endcase
   end

   assign pt_on   = (pt_x >= 0) && (pt_x < COLS_S) && (pt_y >= 0) && (pt_y < ROWS_S);
   assign pt_addr = AW'(pt_y[csrd_pkg::SIZE_W-1:0]) * AW'(COLS)
                  + AW'(pt_x[csrd_pkg::SIZE_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         init_ff       <= 1'b1;
         fill_ff       <= '0;
         mem_wr_en_ff  <= 1'b0;
         mem_rd_en_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mem_wr_en_ff  <= 1'b0;
         mem_rd_en_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_FILL: begin
               mem_wr_en_ff   <= 1'b1;
               mem_wr_addr_ff <= fill_ff;
               mem_wr_data_ff <= init_ff ? '0 : chars.clear_char;
               if (fill_ff == LAST_CELL) begin
                  state_ff <= S_IDLE;
                  init_ff  <= 1'b0;
                  if (!init_ff) begin
                     rsp_strobe_ff      <= 1'b1;
                     rsp_write_count_ff <= '0;
                     rsp_read_char_ff   <= '0;
                  end
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (start) begin
                  unique case (cmd)
                     csrd_pkg::CMD_CLEAR: begin
                        fill_ff  <= '0;
                        state_ff <= S_FILL;
                     end
                     csrd_pkg::CMD_SET: begin
                        mem_wr_en_ff       <= pt_on;
                        mem_wr_addr_ff     <= pt_addr;
                        mem_wr_data_ff     <= req_cell_char;
                        rsp_strobe_ff      <= 1'b1;
                        rsp_write_count_ff <= csrd_pkg::COUNT_W'(pt_on);
                        rsp_read_char_ff   <= '0;
                     end
                     csrd_pkg::CMD_RECT: begin
                        x0_ff    <= req_x;
                        y0_ff    <= req_y;
                        x1_ff    <= req_x + $signed({3'b000, req_rect_width});
                        y1_ff    <= req_y + $signed({3'b000, req_rect_height});
                        i_ff     <= req_x;
                        side_ff  <= 1'b0;
                        count_ff <= '0;
                        state_ff <= S_HORIZ;
                     end
                     csrd_pkg::CMD_READ: begin
                        if (pt_on) begin
                           mem_rd_en_ff   <= 1'b1;
                           mem_rd_addr_ff <= pt_addr;
                           state_ff       <= S_RD_WAIT;
                        end else begin
                           rsp_strobe_ff      <= 1'b1;
                           rsp_write_count_ff <= '0;
                           rsp_read_char_ff   <= '0;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_HORIZ: begin
               if (i_ff < x1_ff) begin
                  mem_wr_en_ff   <= pt_on;
                  mem_wr_addr_ff <= pt_addr;
                  mem_wr_data_ff <= chars.horiz_char;
                  count_ff       <= count_ff + csrd_pkg::COUNT_W'(pt_on);
                  side_ff        <= ~side_ff;
                  if (side_ff) begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  i_ff     <= y0_ff;
                  side_ff  <= 1'b0;
                  state_ff <= S_VERT;
               end
            end
            S_VERT: begin
               if (i_ff < y1_ff) begin
                  mem_wr_en_ff   <= pt_on;
                  mem_wr_addr_ff <= pt_addr;
                  mem_wr_data_ff <= chars.vert_char;
                  count_ff       <= count_ff + csrd_pkg::COUNT_W'(pt_on);
                  side_ff        <= ~side_ff;
                  if (side_ff) begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  k_ff     <= '0;
                  state_ff <= S_CORNER;
               end
            end
            S_CORNER: begin
               mem_wr_en_ff   <= pt_on;
               mem_wr_addr_ff <= pt_addr;
               mem_wr_data_ff <= chars.corner_char;
               if (k_ff == 2'd3) begin
                  rsp_strobe_ff      <= 1'b1;
                  rsp_write_count_ff <= count_ff;
                  rsp_read_char_ff   <= '0;
                  state_ff           <= S_IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_RD_WAIT: begin
               state_ff <= S_RD_TAKE;
            end
            S_RD_TAKE: begin
               rsp_strobe_ff      <= 1'b1;
               rsp_write_count_ff <= '0;
               rsp_read_char_ff   <= mem_rd_data;
               state_ff           <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign mem_wr_en       = mem_wr_en_ff;
   assign mem_wr_addr     = mem_wr_addr_ff;
   assign mem_wr_data     = mem_wr_data_ff;
   assign mem_rd_en       = mem_rd_en_ff;
   assign mem_rd_addr     = mem_rd_addr_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_write_count = rsp_write_count_ff;
   assign rsp_read_char   = rsp_read_char_ff;

endmodule

### rtl/char_screen_rect_drawer.sv
// ----------------------------------------------------------------------------
// char_screen_rect_drawer
// character frame buffer of COLS x ROWS cells with clear, set, rectangle
// outline and read commands
// ----------------------------------------------------------------------------
// clear sweeps every cell; rectangle walks both horizontal edges, then both vertical
//    edges, then the four corners; at most one write to the cell memory a cycle
// throughput: one item at a time; busy, if raised, falls with its result strobe
// reset: a pass over all COLS*ROWS cells zeroes the cell memory with busy high;
//    configuration writes are taken during that pass
// the receiver cannot stall: each result is on rsp_ for one cycle only
module char_screen_rect_drawer #(
   parameter int COLS = csrd_pkg::DEF_COLS,
   parameter int ROWS = csrd_pkg::DEF_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic signed [csrd_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [csrd_pkg::POS_W-1:0]   req_pos_y,
   input  logic [csrd_pkg::SIZE_W-1:0]         req_rect_width,
   input  logic [csrd_pkg::SIZE_W-1:0]         req_rect_height,
   input  logic [csrd_pkg::CHAR_W-1:0]         req_cell_char,
   output logic                                rsp_strobe,
   output logic [csrd_pkg::COUNT_W-1:0]        rsp_write_count,
   output logic [csrd_pkg::CHAR_W-1:0]         rsp_read_char,
   input  logic                                csr_write_en,
   input  logic [csrd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csrd_pkg::CHAR_W-1:0]         csr_wdata
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

   csrd_pkg::char_set_type              chars_ff;
   logic                                mem_wr_en;
   logic [AW-1:0]                       mem_wr_addr;
   logic [csrd_pkg::CHAR_W-1:0]         mem_wr_data;
   logic                                mem_rd_en;
   logic [AW-1:0]                       mem_rd_addr;
   logic [csrd_pkg::CHAR_W-1:0]         mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff.clear_char  <= csrd_pkg::RST_CLEAR_CHAR;
         chars_ff.horiz_char  <= csrd_pkg::RST_HORIZ_CHAR;
         chars_ff.vert_char   <= csrd_pkg::RST_VERT_CHAR;
         chars_ff.corner_char <= csrd_pkg::RST_CORNER_CHAR;
      end else if (csr_write_en) begin
         unique case (csrd_pkg::reg_idx_type'(csr_index))
            csrd_pkg::REG_CLEAR_CHAR:  chars_ff.clear_char  <= csr_wdata;
            csrd_pkg::REG_HORIZ_CHAR:  chars_ff.horiz_char  <= csr_wdata;
            csrd_pkg::REG_VERT_CHAR:   chars_ff.vert_char   <= csr_wdata;
            csrd_pkg::REG_CORNER_CHAR: chars_ff.corner_char <= csr_wdata;
            default: begin
               chars_ff <= chars_ff;
            end
         endcase
      end
   end

   csrd_draw_seq #(
      .COLS (COLS),
      .ROWS (ROWS),
      .AW   (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_cell_char   (req_cell_char),
      .chars           (chars_ff),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_write_count (rsp_write_count),
      .rsp_read_char   (rsp_read_char)
   );

   csrd_cell_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
